// File: src/assert_macros.svh
// Assertion helpers for the checker file (cso_checker.sv)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cso_pkg.sv
`default_nettype none
package cso_pkg;

  localparam int ALPHABET_SIZE = 256;
  localparam int SYM_W = 8;
  localparam int CNT_W = 9;
  localparam int CUR_W = 10;
  localparam int OP_W  = 2;

  typedef enum logic [1:0] {
    CMD_APPEND_A = 2'd0,
    CMD_APPEND_B = 2'd1,
    CMD_FETCH    = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  localparam logic [OP_W-1:0] OP_INTERSECT = 2'd0;
  localparam logic [OP_W-1:0] OP_UNION     = 2'd1;
  localparam logic [OP_W-1:0] OP_DIFF      = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE      = 2'd3;

endpackage
`default_nettype wire

// File: src/char_set_operation_engine.sv
// Character set operation engine.
// Request channel: in_command/in_symbol taken when start is high and busy low.
// Append A/B and clear finish in the accepting cycle; their result strobe
// (out_strobe, symbol 0, valid 0) follows in the next cycle, busy stays low.
// A fetch raises busy and walks the result list through the registered reads
// of the two order lists and one membership check; each list position visited
// passes through ST_ADDR (read) and then ST_CHECK (check). The fetch answers
// when a visited position is taken, or with an empty result when the walk runs
// out (at most count_a + count_b positions visited, i.e. up to 512 positions).
// One request is in flight at a time.
// out_strobe marks each result for exactly one cycle; the receiver cannot
// stall. cfg_wr_en writes set_operation and restarts the walk; write only
// while busy is low.
// Synchronous reset (rst_n low) empties both sets, zeroes the counts, the
// walk cursor and the operation register, and drops busy and out_strobe.
`default_nettype none
module char_set_operation_engine
  import cso_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       in_command,
  input  wire logic [SYM_W-1:0] in_symbol,
  output logic                  out_strobe,
  output logic [SYM_W-1:0]      out_result_symbol,
  output logic                  out_result_valid,
  input  wire logic             cfg_wr_en,
  input  wire logic [OP_W-1:0]  cfg_set_operation
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADDR,
    ST_CHECK
  } state_t;

  state_t state_r, state_nxt;

  logic [ALPHABET_SIZE-1:0] member_a_r, member_a_nxt;
  logic [ALPHABET_SIZE-1:0] member_b_r, member_b_nxt;
  logic [CNT_W-1:0]         count_a_r, count_a_nxt;
  logic [CNT_W-1:0]         count_b_r, count_b_nxt;
  logic [CUR_W-1:0]         cursor_r, cursor_nxt;
  logic [OP_W-1:0]          op_r, op_nxt;
  logic                     from_b_r, from_b_nxt;
  logic                     strobe_r, strobe_nxt;
  logic [SYM_W-1:0]         res_sym_r, res_sym_nxt;
  logic                     res_valid_r, res_valid_nxt;

  logic [SYM_W-1:0] order_a [ALPHABET_SIZE];
  logic [SYM_W-1:0] order_b [ALPHABET_SIZE];
  logic [SYM_W-1:0] rdata_a_r;
  logic [SYM_W-1:0] rdata_b_r;

  logic             accept;
  cmd_t             cmd;
  logic             sym_ok;
  logic             load_a;
  logic             load_b;
  logic [CNT_W-1:0] nb;
  logic [CUR_W-1:0] total;
  logic [CNT_W-1:0] pos;
  logic             in_b;
  logic [CNT_W-1:0] idx_a;
  logic [CNT_W-1:0] idx_b;
  logic [SYM_W-1:0] chk_sym;
  logic             keep;

  assign busy              = (state_r != ST_IDLE);
  assign accept            = start && !busy;
  assign cmd               = cmd_t'(in_command);
  assign out_strobe        = strobe_r;
  assign out_result_symbol = res_sym_r;
  assign out_result_valid  = res_valid_r;

  assign sym_ok = ({1'b0, in_symbol} < CNT_W'(ALPHABET_SIZE));
  assign load_a = accept && (cmd == CMD_APPEND_A) && sym_ok && !member_a_r[in_symbol]
                  && (count_a_r < CNT_W'(ALPHABET_SIZE));
  assign load_b = accept && (cmd == CMD_APPEND_B) && sym_ok && !member_b_r[in_symbol]
                  && (count_b_r < CNT_W'(ALPHABET_SIZE));

  assign nb    = (op_r == OP_UNION) ? count_b_r : '0;
  assign total = (op_r == OP_NONE) ? '0 : (CUR_W'(nb) + CUR_W'(count_a_r));
  assign pos   = cursor_r[CNT_W-1:0];
  assign in_b  = (cursor_r < CUR_W'(nb));
  assign idx_b = count_b_r - CNT_W'(1) - pos;
  assign idx_a = count_a_r - CNT_W'(1) - (pos - nb);

  assign chk_sym = from_b_r ? rdata_b_r : rdata_a_r;

  always_comb begin
    if (from_b_r) begin
      keep = !member_a_r[chk_sym];
    end else begin
      case (op_r)
        OP_INTERSECT: keep = member_b_r[chk_sym];
        OP_DIFF:      keep = !member_b_r[chk_sym];
        default:      keep = 1'b1;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    member_a_nxt  = member_a_r;
    member_b_nxt  = member_b_r;
    count_a_nxt   = count_a_r;
    count_b_nxt   = count_b_r;
    cursor_nxt    = cursor_r;
    op_nxt        = op_r;
    from_b_nxt    = from_b_r;
    strobe_nxt    = 1'b0;
    res_sym_nxt   = res_sym_r;
    res_valid_nxt = res_valid_r;

    if (cfg_wr_en) begin
      op_nxt     = cfg_set_operation;
      cursor_nxt = '0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_APPEND_A: begin
              if (load_a) begin
                member_a_nxt[in_symbol] = 1'b1;
                count_a_nxt = count_a_r + CNT_W'(1);
                cursor_nxt  = '0;
              end
            end
            CMD_APPEND_B: begin
              if (load_b) begin
                member_b_nxt[in_symbol] = 1'b1;
                count_b_nxt = count_b_r + CNT_W'(1);
                cursor_nxt  = '0;
              end
            end
            CMD_CLEAR: begin
              member_a_nxt = '0;
              member_b_nxt = '0;
              count_a_nxt  = '0;
              count_b_nxt  = '0;
              cursor_nxt   = '0;
            end
            CMD_FETCH: begin
              state_nxt = ST_ADDR;
            end
          endcase
          if (cmd != CMD_FETCH) begin
            strobe_nxt    = 1'b1;
            res_sym_nxt   = '0;
            res_valid_nxt = 1'b0;
          end
        end
      end
      ST_ADDR: begin
        if (cursor_r >= total) begin
          state_nxt     = ST_IDLE;
          strobe_nxt    = 1'b1;
          res_sym_nxt   = '0;
          res_valid_nxt = 1'b0;
        end else begin
          from_b_nxt = in_b;
          cursor_nxt = cursor_r + CUR_W'(1);
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (keep) begin
          state_nxt     = ST_IDLE;
          strobe_nxt    = 1'b1;
          res_sym_nxt   = chk_sym;
          res_valid_nxt = 1'b1;
        end else begin
          state_nxt = ST_ADDR;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      member_a_r <= '0;
      member_b_r <= '0;
      count_a_r  <= '0;
      count_b_r  <= '0;
      cursor_r   <= '0;
      op_r       <= OP_INTERSECT;
      from_b_r   <= 1'b0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      member_a_r <= member_a_nxt;
      member_b_r <= member_b_nxt;
      count_a_r  <= count_a_nxt;
      count_b_r  <= count_b_nxt;
      cursor_r   <= cursor_nxt;
      op_r       <= op_nxt;
      from_b_r   <= from_b_nxt;
      strobe_r   <= strobe_nxt;
    end
    res_sym_r   <= res_sym_nxt;
    res_valid_r <= res_valid_nxt;
  end

  // order lists: one write and one registered read per list
  always_ff @(posedge clk) begin
    if (load_a) begin
      order_a[count_a_r[SYM_W-1:0]] <= in_symbol;
    end
    if (load_b) begin
      order_b[count_b_r[SYM_W-1:0]] <= in_symbol;
    end
    rdata_a_r <= order_a[idx_a[SYM_W-1:0]];
    rdata_b_r <= order_b[idx_b[SYM_W-1:0]];
  end

endmodule
`default_nettype wire

// File: src/cso_checker.sv
`default_nettype none
`include "assert_macros.svh"
module cso_checker
  import cso_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic [1:0]       in_command,
  input wire logic             out_strobe,
  input wire logic [SYM_W-1:0] out_result_symbol,
  input wire logic             out_result_valid
);

  logic req_taken;
  logic non_fetch;

  assign req_taken = start && !busy;
  assign non_fetch = (in_command != CMD_FETCH);

  `ASSERT_NEXT(a_req_progress, clk, rst_n, req_taken, out_strobe || busy, "request stalled")
  `ASSERT_NEXT(a_nonfetch_reply, clk, rst_n, req_taken && non_fetch, out_strobe && !out_result_valid && !busy, "bad non-fetch reply")
  `ASSERT_SAME(a_fetch_done, clk, rst_n, $fell(busy), out_strobe, "fetch ended without result")
  `ASSERT_SAME(a_strobe_idle, clk, rst_n, out_strobe, !busy, "result while busy")
  `ASSERT_SAME(a_empty_zero, clk, rst_n, out_strobe && !out_result_valid, out_result_symbol == '0, "empty result not zero")

endmodule

bind char_set_operation_engine cso_checker u_cso_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_command        (in_command),
  .out_strobe        (out_strobe),
  .out_result_symbol (out_result_symbol),
  .out_result_valid  (out_result_valid)
);
`default_nettype wire

// File: tb/char_set_operation_engine_test.sv
`timescale 1ns / 1ps
module char_set_operation_engine_test;
  import cso_pkg::*;

  localparam int ITEMS       = 1050;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN       = 20;
  localparam int NSTEPS      = 26;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             valid;
  } answer_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    cmd_t            cmd;
    logic [OP_W-1:0] op;
    logic [SYM_W-1:0] sym;
    logic            typed;
    answer_t         ans;
  } step_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_command;
  logic [SYM_W-1:0] in_symbol;
  logic             out_strobe;
  logic [SYM_W-1:0] out_result_symbol;
  logic             out_result_valid;
  logic             cfg_wr_en;
  logic [OP_W-1:0]  cfg_set_operation;

  // typed-in answer travels with its request
  logic    use_typed;
  answer_t typed_ans;

  // model of the set store
  bit               in_a [ALPHABET_SIZE];
  bit               in_b [ALPHABET_SIZE];
  logic [SYM_W-1:0] seq_a [ALPHABET_SIZE];
  logic [SYM_W-1:0] seq_b [ALPHABET_SIZE];
  int               size_a;
  int               size_b;
  int               walk_pos;
  logic [OP_W-1:0]  op_sel;

  answer_t pending_answers [$];
  int      fail_count;
  int      quiet_cycles;
  int      sent;
  int      idle_pct;
  step_t   script [NSTEPS];

  char_set_operation_engine dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_symbol        (in_symbol),
    .out_strobe       (out_strobe),
    .out_result_symbol(out_result_symbol),
    .out_result_valid (out_result_valid),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_set_operation(cfg_set_operation)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic answer_t next_set_member();
    answer_t res;
    int nb;
    int total;
    int pos;
    logic [SYM_W-1:0] s;
    bit keep;
    res = '0;
    nb = (op_sel == OP_UNION) ? size_b : 0;
    total = (op_sel == OP_NONE) ? 0 : nb + size_a;
    while (walk_pos < total && !res.valid) begin
      pos = walk_pos;
      walk_pos++;
      if (pos < nb) begin
        s = seq_b[size_b - 1 - pos];
        keep = !in_a[s];
      end else begin
        s = seq_a[size_a - 1 - (pos - nb)];
        case (op_sel)
          OP_INTERSECT: keep = in_b[s];
          OP_DIFF:      keep = !in_b[s];
          default:      keep = 1'b1;
        endcase
      end
      if (keep) begin
        res.sym = s;
        res.valid = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic answer_t apply_request(cmd_t cmd, logic [SYM_W-1:0] s);
    answer_t res;
    res = '0;
    case (cmd)
      CMD_APPEND_A: begin
        if (!in_a[s] && size_a < ALPHABET_SIZE) begin
          in_a[s] = 1'b1;
          seq_a[size_a] = s;
          size_a++;
          walk_pos = 0;
        end
      end
      CMD_APPEND_B: begin
        if (!in_b[s] && size_b < ALPHABET_SIZE) begin
          in_b[s] = 1'b1;
          seq_b[size_b] = s;
          size_b++;
          walk_pos = 0;
        end
      end
      CMD_FETCH: res = next_set_member();
      default: begin
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
          in_a[i] = 1'b0;
          in_b[i] = 1'b0;
        end
        size_a = 0;
        size_b = 0;
        walk_pos = 0;
      end
    endcase
    return res;
  endfunction

  // result check first, then the request taken at this edge, then the register
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (rst_n) begin
      if (out_strobe) begin
        got.sym = out_result_symbol;
        got.valid = out_result_valid;
        if (pending_answers.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result symbol %h valid %b", $time, got.sym, got.valid);
          fail_count++;
        end else begin
          want = pending_answers.pop_front();
          if (got.sym !== want.sym || got.valid !== want.valid) begin
            if (fail_count < 10)
              $display("%0t: mismatch symbol exp %h got %h, valid exp %b got %b",
                       $time, want.sym, got.sym, want.valid, got.valid);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        want = apply_request(cmd_t'(in_command), in_symbol);
        if (use_typed)
          want = typed_ans;
        pending_answers.push_back(want);
      end
      if (cfg_wr_en) begin
        op_sel = cfg_set_operation;
        walk_pos = 0;
      end
      if (out_strobe || (start && !busy))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  task automatic issue(cmd_t cmd, logic [SYM_W-1:0] s, logic typed, answer_t ans);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_symbol <= s;
    use_typed <= typed;
    typed_ans <= ans;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // register is written only with nothing in flight
  task automatic write_operation(logic [OP_W-1:0] op);
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending_answers.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_set_operation <= op;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [OP_W-1:0] random_operation();
    if ($urandom_range(0, 9) == 0)
      return OP_NONE;
    case ($urandom_range(0, 2))
      0:       return OP_INTERSECT;
      1:       return OP_UNION;
      default: return OP_DIFF;
    endcase
  endfunction

  initial begin : watchdog
    @(posedge rst_n);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [SYM_W-1:0] pool [16];
    logic [SYM_W-1:0] perm [ALPHABET_SIZE];
    logic [SYM_W-1:0] tmp;
    logic [SYM_W-1:0] s;
    int pool_n;
    int loads;
    int fetches;
    int phase;
    int r;
    int j;

    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_FETCH;
    in_symbol = '0;
    cfg_wr_en = 1'b0;
    cfg_set_operation = OP_INTERSECT;
    use_typed = 1'b0;
    typed_ans = '0;
    op_sel = OP_INTERSECT;
    idle_pct = 28;

    script = '{
      '{ROW_REQ, CMD_FETCH,    OP_INTERSECT, 8'h00, 1'b1, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_APPEND_A, OP_INTERSECT, 8'h00, 1'b1, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_APPEND_A, OP_INTERSECT, 8'hff, 1'b1, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_APPEND_A, OP_INTERSECT, 8'h00, 1'b1, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_APPEND_B, OP_INTERSECT, 8'hff, 1'b1, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_APPEND_B, OP_INTERSECT, 8'h80, 1'b1, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_FETCH,    OP_INTERSECT, 8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_FETCH,    OP_INTERSECT, 8'hff, 1'b1, '{8'h00, 1'b0}},
      '{ROW_CFG, CMD_FETCH,    OP_UNION,     8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_FETCH,    OP_INTERSECT, 8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_FETCH,    OP_INTERSECT, 8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_FETCH,    OP_INTERSECT, 8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_FETCH,    OP_INTERSECT, 8'h00, 1'b1, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_APPEND_B, OP_INTERSECT, 8'h00, 1'b1, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_FETCH,    OP_INTERSECT, 8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_CFG, CMD_FETCH,    OP_DIFF,      8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_FETCH,    OP_INTERSECT, 8'h00, 1'b1, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_APPEND_A, OP_INTERSECT, 8'h55, 1'b1, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_APPEND_A, OP_INTERSECT, 8'haa, 1'b1, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_FETCH,    OP_INTERSECT, 8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_CFG, CMD_FETCH,    OP_NONE,      8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_FETCH,    OP_INTERSECT, 8'h00, 1'b1, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_CLEAR,    OP_INTERSECT, 8'hff, 1'b1, '{8'h00, 1'b0}},
      '{ROW_CFG, CMD_FETCH,    OP_INTERSECT, 8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_CFG, CMD_FETCH,    OP_UNION,     8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_REQ, CMD_FETCH,    OP_INTERSECT, 8'h00, 1'b1, '{8'h00, 1'b0}}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NSTEPS; i++) begin
      if (script[i].kind == ROW_CFG)
        write_operation(script[i].op);
      else
        issue(script[i].cmd, script[i].sym, script[i].typed, script[i].ans);
    end

    phase = 0;
    while (sent < ITEMS) begin
      phase++;
      idle_pct = (phase >= 12 && phase < 22) ? 0 : 28;
      if ($urandom_range(0, 9) < 8)
        write_operation(random_operation());
      if ($urandom_range(0, 4) != 0)
        issue(CMD_CLEAR, SYM_W'($urandom_range(0, 255)), 1'b0, '0);
      if (phase == 5) begin
        // fill A with the whole alphabet in random order
        for (int i = 0; i < ALPHABET_SIZE; i++)
          perm[i] = SYM_W'(i);
        for (int i = ALPHABET_SIZE - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (int i = 0; i < ALPHABET_SIZE; i++)
          issue(CMD_APPEND_A, perm[i], 1'b0, '0);
        repeat (48) issue(CMD_APPEND_B, SYM_W'($urandom_range(0, 255)), 1'b0, '0);
        fetches = 60;
      end else begin
        pool_n = $urandom_range(1, 16);
        for (int i = 0; i < pool_n; i++)
          pool[i] = SYM_W'($urandom_range(0, 255));
        loads = $urandom_range(0, 14);
        repeat (loads) begin
          if ($urandom_range(0, 7) == 0)
            s = SYM_W'($urandom_range(0, 255));
          else
            s = pool[$urandom_range(0, pool_n - 1)];
          issue($urandom_range(0, 1) ? CMD_APPEND_B : CMD_APPEND_A, s, 1'b0, '0);
        end
        fetches = $urandom_range(2, 18);
      end
      repeat (fetches) begin
        r = $urandom_range(0, 99);
        if (r < 8)
          issue($urandom_range(0, 1) ? CMD_APPEND_B : CMD_APPEND_A,
                pool[$urandom_range(0, pool_n - 1)], 1'b0, '0);
        else if (r < 10)
          issue(CMD_CLEAR, SYM_W'($urandom_range(0, 255)), 1'b0, '0);
        else
          issue(CMD_FETCH, SYM_W'($urandom_range(0, 255)), 1'b0, '0);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
